FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on the rising edge of clock
// and are switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge.
`define ALS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define ALS_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/als_pkg.sv
package als_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;

   typedef logic [IDX_W-1:0] als_idx_type;
   typedef logic [CNT_W-1:0] als_cnt_type;
   typedef logic [3:0]       als_slot_type;
   typedef logic [4:0]       als_entries_type;

   // Command codes.
   localparam logic [2:0] OP_LIST    = 3'd0;
   localparam logic [2:0] OP_FIND    = 3'd1;
   localparam logic [2:0] OP_DEL_VAL = 3'd2;
   localparam logic [2:0] OP_APPEND  = 3'd3;
   localparam logic [2:0] OP_DEL_AT  = 3'd4;

   // Result status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_BAD_INDEX = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [31:0]  value;
      logic [3:0]          position;
   } als_req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic signed [31:0]  element;
      als_slot_type        slot;
      als_entries_type     entries;
      logic                last;
   } als_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_SHIFT,
      S_FLUSH
   } als_state_type;

endpackage

FILE: hw/rtl/als_ram.sv
module als_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/array_list_store.sv
// Packed list of signed 32-bit words held in a single-port-read RAM.
// Commands arrive on the req_ channel (valid/stall); one beat is one command.
// Results leave on the rsp_ channel; the last beat of a command has last set.
// A command is taken only when the previous one has finished and all of its
// results have been loaded into the output register.
// List and find walk the stored elements one per cycle through the RAM read
// port, save where a stall on rsp_ pauses the walk as described below.
// Delete by value scans all elements, then shifts the tail down one entry per
// cycle. Delete at index fetches the entry at its position, then shifts likewise.
// Append, and the empty, full and bad-index statuses, go from idle straight to flush.
// A stall on rsp_ holds the output register; a list or find walk pauses only
// when its next hit is ready while one beat waits there and another is held.
// Reset empties the list at once; stored words are not cleared and are never
// used before they are written.
module array_list_store (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  als_pkg::als_req_type req_beat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output als_pkg::als_rsp_type rsp_beat
);

`include "assert_macros.svh"

   als_pkg::als_state_type state_ff, state_in;
   als_pkg::als_idx_type   idx_ff, idx_in;
   als_pkg::als_idx_type   hit_idx_ff, hit_idx_in;
   als_pkg::als_cnt_type   count_ff, count_in;
   logic                   hit_ff, hit_in;
   logic [2:0]             op_ff, op_in;
   logic signed [31:0]     value_ff, value_in;
   logic                   pend_valid_ff, pend_valid_in;
   als_pkg::als_rsp_type   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   als_pkg::als_rsp_type   rsp_ff, rsp_in;

   als_pkg::als_idx_type   rd_addr;
   als_pkg::als_idx_type   wr_addr;
   logic                   mem_we;
   logic [31:0]            wr_data;
   logic [31:0]            rd_data;

   als_pkg::als_cnt_type   count_m1;
   logic                   out_free;
   logic                   scan_last;
   logic                   match;
   logic                   take;
   logic                   load_out;
   logic                   out_last;
   logic                   shift_go;
   als_pkg::als_idx_type   shift_k;
   logic signed [31:0]     shift_elem;

   logic                   append_go;
   logic                   shift_done;
   logic                   flushing;

   als_ram #(
      .DEPTH (als_pkg::CAPACITY),
      .WIDTH (als_pkg::WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_m1  = count_ff - 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (als_pkg::als_cnt_type'(idx_ff) == count_m1);
   assign match     = ($signed(rd_data) == value_ff);
   assign take      = (op_ff == als_pkg::OP_LIST) || match;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      hit_idx_in    = hit_idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      rd_addr       = idx_ff;
      wr_addr       = idx_ff;
      mem_we        = 1'b0;
      wr_data       = rd_data;
      load_out      = 1'b0;
      out_last      = 1'b0;
      shift_go      = 1'b0;
      shift_k       = '0;
      shift_elem    = '0;

      case (state_ff)
         als_pkg::S_IDLE: begin
            if (req_valid && req_beat.op <= als_pkg::OP_DEL_AT) begin
               op_in    = req_beat.op;
               value_in = req_beat.value;
               pend_in  = '0;
               if (req_beat.op != als_pkg::OP_APPEND && count_ff == '0) begin
                  pend_in.status = als_pkg::STAT_EMPTY;
                  pend_valid_in  = 1'b1;
                  state_in       = als_pkg::S_FLUSH;
               end else if (req_beat.op == als_pkg::OP_APPEND) begin
                  pend_valid_in = 1'b1;
                  state_in      = als_pkg::S_FLUSH;
                  if (count_ff >= als_pkg::als_cnt_type'(als_pkg::CAPACITY)) begin
                     pend_in.status = als_pkg::STAT_FULL;
                  end else begin
                     mem_we          = 1'b1;
                     wr_addr         = count_ff[als_pkg::IDX_W-1:0];
                     wr_data         = req_beat.value;
                     count_in        = count_ff + 1'b1;
                     pend_in.status  = als_pkg::STAT_OK;
                     pend_in.element = req_beat.value;
                     pend_in.slot    = als_pkg::als_slot_type'(count_ff);
                  end
               end else if (req_beat.op == als_pkg::OP_DEL_AT) begin
                  if (als_pkg::als_cnt_type'(req_beat.position) >= count_ff) begin
                     pend_in.status = als_pkg::STAT_BAD_INDEX;
                     pend_valid_in  = 1'b1;
                     state_in       = als_pkg::S_FLUSH;
                  end else begin
                     idx_in   = als_pkg::als_idx_type'(req_beat.position);
                     rd_addr  = als_pkg::als_idx_type'(req_beat.position);
                     state_in = als_pkg::S_FETCH;
                  end
               end else begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  hit_in   = 1'b0;
                  state_in = als_pkg::S_SCAN;
               end
            end
         end

         als_pkg::S_SCAN: begin
            if (op_ff == als_pkg::OP_DEL_VAL) begin
               // Remember the highest matching slot; the shift starts there.
               if (match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff;
               end
               if (scan_last) begin
                  if (match || hit_ff) begin
                     shift_go   = 1'b1;
                     shift_k    = match ? idx_ff : hit_idx_ff;
                     shift_elem = value_ff;
                  end else begin
                     pend_in        = '0;
                     pend_in.status = als_pkg::STAT_NOT_FOUND;
                     pend_valid_in  = 1'b1;
                     state_in       = als_pkg::S_FLUSH;
                  end
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end else if (!(take && pend_valid_ff && !out_free)) begin
               // A hit is held in the pending register so that the final beat can carry last.
               if (take) begin
                  if (pend_valid_ff) begin
                     load_out = 1'b1;
                  end
                  pend_valid_in   = 1'b1;
                  pend_in         = '0;
                  pend_in.status  = als_pkg::STAT_OK;
                  pend_in.element = $signed(rd_data);
                  pend_in.slot    = als_pkg::als_slot_type'(idx_ff);
               end
               if (scan_last) begin
                  state_in = als_pkg::S_FLUSH;
                  if (!take && !pend_valid_ff) begin
                     pend_in        = '0;
                     pend_in.status = als_pkg::STAT_NOT_FOUND;
                     pend_valid_in  = 1'b1;
                  end
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end

         als_pkg::S_FETCH: begin
            shift_go   = 1'b1;
            shift_k    = idx_ff;
            shift_elem = $signed(rd_data);
         end

         als_pkg::S_SHIFT: begin
            // Writes trail reads by two entries, so no access collides.
            mem_we  = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data;
            if (scan_last) begin
               count_in = count_m1;
               state_in = als_pkg::S_FLUSH;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         als_pkg::S_FLUSH: begin
            if (out_free) begin
               load_out      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = als_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = als_pkg::S_IDLE;
         end
      endcase

      if (shift_go) begin
         pend_valid_in   = 1'b1;
         pend_in         = '0;
         pend_in.status  = als_pkg::STAT_OK;
         pend_in.element = shift_elem;
         pend_in.slot    = als_pkg::als_slot_type'(shift_k);
         if (als_pkg::als_cnt_type'(shift_k) == count_m1) begin
            count_in = count_m1;
            state_in = als_pkg::S_FLUSH;
         end else begin
            idx_in   = shift_k + 1'b1;
            rd_addr  = shift_k + 1'b1;
            state_in = als_pkg::S_SHIFT;
         end
      end

      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_in         = pend_ff;
         rsp_in.entries = als_pkg::als_entries_type'(count_ff);
         rsp_in.last    = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= als_pkg::S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_ff        <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      hit_idx_ff <= hit_idx_in;
      op_ff      <= op_in;
      value_ff   <= value_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != als_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   assign append_go  = (state_ff == als_pkg::S_IDLE) && req_valid &&
                       (req_beat.op == als_pkg::OP_APPEND);
   assign shift_done = (state_ff == als_pkg::S_SHIFT) && scan_last;
   assign flushing   = (state_ff == als_pkg::S_FLUSH);

   // The count moves by at most one per cycle, so the difference plus one wraps into 0..2.
   `ALS_ASSERT(a_count_step, count_ff - $past(count_ff) + 1'b1 <= 5'd2, "count jumped")
   `ALS_ASSERT(a_idle_no_pend, (state_ff == als_pkg::S_IDLE) |-> !pend_valid_ff, "pend at idle")
   `ALS_ASSERT(a_write_src, mem_we |-> ((state_ff == als_pkg::S_SHIFT) || append_go), "stray write")
   `ALS_ASSERT_NEXT(a_shift_end, shift_done, flushing && count_ff == $past(count_ff) - 1'b1, "bad shift")

endmodule
